[rtl/gpc_pkg.sv]
// gpc_pkg: shared types and constants for the grid path counter
// used by the cell, chain, step and top-level modules; no dependencies
package gpc_pkg;

   localparam int COUNT_W    = 30;
   localparam int CSR_W      = 11;
   // wide enough to compare a size register value against any supported depth
   localparam int SIZE_CMP_W = 13;

   typedef logic [COUNT_W-1:0] count_type;

   localparam count_type PATH_MOD = 30'd1000000007;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

[rtl/gpc_cell.sv]
// gpc_cell: one stage of the row store delay chain
// depends on gpc_pkg for the count and control types
module gpc_cell
   import gpc_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  count_type     new_count,
   input  count_type     prev_count,
   output count_type     count
);

   count_type count_ff;
   count_type count_in;

   // on a shift the insert point takes the fresh count, the others their neighbor
   always_comb begin
      count_in = count_ff;
      if (ctrl.shift) begin
         count_in = ctrl.load ? new_count : prev_count;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
   end

   assign count = count_ff;

endmodule

[rtl/gpc_chain.sv]
// gpc_chain: row of gpc_cell stages acting as an n-deep delay line
// depends on gpc_pkg and gpc_cell
module gpc_chain
   import gpc_pkg::*;
#(
   parameter int MAX_SIZE = 1024,
   parameter int IDX_W    = 10
)(
   input  logic             clock,
   input  logic             shift,
   input  logic [IDX_W-1:0] ins_pos,
   input  count_type        new_count,
   output count_type        tail_count
);

   count_type chain_count [MAX_SIZE];

   for (genvar i = 0; i < MAX_SIZE; i++) begin : g_cell
      cell_ctrl_type cell_ctrl;
      count_type     prev_count;

      assign cell_ctrl.shift = shift;
      assign cell_ctrl.load  = (ins_pos == IDX_W'(i));

      if (i == 0) begin : g_head
         assign prev_count = new_count;
      end else begin : g_body
         assign prev_count = chain_count[i-1];
      end

      gpc_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .new_count  (new_count),
         .prev_count (prev_count),
         .count      (chain_count[i])
      );
   end

   assign tail_count = chain_count[MAX_SIZE-1];

endmodule

[rtl/gpc_step.sv]
// gpc_step: count for one grid cell from the counts above and to the left
// depends on gpc_pkg for the modulus and count type
module gpc_step
   import gpc_pkg::*;
(
   input  logic      is_trap,
   input  logic      top_row,
   input  logic      first_col,
   input  count_type above_count,
   input  count_type left_count,
   output count_type count
);

   logic [COUNT_W:0] sum;
   count_type        above_use;
   count_type        left_use;

   assign above_use = top_row   ? '0 : above_count;
   assign left_use  = first_col ? '0 : left_count;
   assign sum       = {1'b0, above_use} + {1'b0, left_use};

   always_comb begin
      if (is_trap) begin
         count = '0;
      end else if (top_row && first_col) begin
         count = count_type'(1);
      end else if (sum >= {1'b0, PATH_MOD}) begin
         count = COUNT_W'(sum - {1'b0, PATH_MOD});
      end else begin
         count = sum[COUNT_W-1:0];
      end
   end

endmodule

[rtl/grid_path_count_mod.sv]
// grid_path_count_mod: streaming path counter over a square grid with traps
// depends on gpc_pkg, gpc_chain (built from gpc_cell) and gpc_step
//
//   port group   direction  contents
//   req_*        in         is_trap, one grid cell per transaction, row-major
//   rsp_*        out        path_count and last_cell, one per request
//   csr_*        in         grid_size write, restarts the grid
//
// one cell per cycle unless stalled; the response register loads next cycle.
// the previous row lives in a chain of MAX_SIZE cells that shifts on every
// accepted request; a count enters at cell MAX_SIZE-n and leaves the tail n
// requests later as the value above. reset clears indices, size, left, valid
// only; chain contents are never read before the current grid writes them.
// a stalled response holds its register and stalls the request side.
module grid_path_count_mod
   import gpc_pkg::*;
#(
   parameter int MAX_SIZE = 1024
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_is_trap,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [COUNT_W-1:0] rsp_path_count,
   output logic               rsp_last_cell,
   input  logic               csr_wr_en,
   input  logic [CSR_W-1:0]   csr_wr_data
);

   localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

   logic [IDX_W-1:0] n_m1_ff, n_m1_in;
   logic [IDX_W-1:0] ins_pos_ff, ins_pos_in;
   logic [IDX_W-1:0] col_ff, col_in;
   logic [IDX_W-1:0] row_ff, row_in;
   count_type        left_ff, left_in;
   logic             rsp_valid_ff, rsp_valid_in;
   count_type        rsp_count_ff, rsp_count_in;
   logic             rsp_last_ff, rsp_last_in;

   logic                  req_accept;
   logic [SIZE_CMP_W-1:0] size_req;
   count_type             above_count;
   count_type             step_count;
   logic                  col_end;
   logic                  row_end;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign col_end    = (col_ff == n_m1_ff);
   assign row_end    = (row_ff == n_m1_ff);
   assign size_req   = SIZE_CMP_W'(csr_wr_data);

   gpc_chain #(
      .MAX_SIZE (MAX_SIZE),
      .IDX_W    (IDX_W)
   ) u_chain (
      .clock      (clock),
      .shift      (req_accept),
      .ins_pos    (ins_pos_ff),
      .new_count  (step_count),
      .tail_count (above_count)
   );

   gpc_step u_step (
      .is_trap     (req_is_trap),
      .top_row     (row_ff == '0),
      .first_col   (col_ff == '0),
      .above_count (above_count),
      .left_count  (left_ff),
      .count       (step_count)
   );

   always_comb begin
      n_m1_in      = n_m1_ff;
      ins_pos_in   = ins_pos_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         // zero acts as one, oversize clamps to the chain depth
         if (size_req == '0) begin
            n_m1_in = '0;
         end else if (size_req > SIZE_CMP_W'(MAX_SIZE)) begin
            n_m1_in = IDX_W'(MAX_SIZE - 1);
         end else begin
            n_m1_in = IDX_W'(size_req - SIZE_CMP_W'(1));
         end
         ins_pos_in = IDX_W'(MAX_SIZE - 1) - n_m1_in;
         col_in     = '0;
         row_in     = '0;
         left_in    = '0;
      end else if (req_accept) begin
         left_in      = step_count;
         rsp_valid_in = 1'b1;
         rsp_count_in = step_count;
         rsp_last_in  = col_end && row_end;
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + IDX_W'(1);
         end else begin
            col_in = col_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_m1_ff      <= '0;
         ins_pos_ff   <= IDX_W'(MAX_SIZE - 1);
         col_ff       <= '0;
         row_ff       <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         n_m1_ff      <= n_m1_in;
         ins_pos_ff   <= ins_pos_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_path_count = rsp_count_ff;
   assign rsp_last_cell  = rsp_last_ff;

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !csr_wr_en) |=> rsp_valid)
      else $error("accepted request produced no response");

   a_origin_is_one: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !csr_wr_en && col_ff == '0 && row_ff == '0 && !req_is_trap)
      |=> (rsp_path_count == COUNT_W'(1)))
      else $error("free top-left cell did not count one");

   a_trap_is_zero: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !csr_wr_en && req_is_trap) |=> (rsp_path_count == '0))
      else $error("trap cell produced a nonzero count");

   a_index_in_grid: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= n_m1_ff) && (row_ff <= n_m1_ff))
      else $error("grid index beyond active size");

endmodule
